[sv/gnps_pkg.sv]
// gnps_pkg: shared types and constants for the gated nearest pose selector.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps

package gnps_pkg;

  // configuration register indexes
  localparam logic [2:0] RegVehicleX      = 3'd0;
  localparam logic [2:0] RegVehicleY      = 3'd1;
  localparam logic [2:0] RegVehicleHead   = 3'd2;
  localparam logic [2:0] RegPosThreshold  = 3'd3;
  localparam logic [2:0] RegAngThreshold  = 3'd4;
  localparam logic [2:0] RegPosWeight     = 3'd5;
  localparam logic [2:0] RegAngWeight     = 3'd6;

  localparam logic [30:0] PosThresholdRst = 31'd131072;
  localparam logic [15:0] AngThresholdRst = 16'd2574;
  localparam logic [31:0] PosWeightRst    = 32'd32768;
  localparam logic [31:0] AngWeightRst    = 32'd208607;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned RootSteps  = 32;

  typedef struct packed {
    logic signed [31:0] cand_x;
    logic signed [31:0] cand_y;
    logic signed [15:0] cand_heading;
    logic               last;
  } cand_t;

  typedef struct packed {
    logic        found;
    logic [7:0]  best_index;
    logic [31:0] best_cost;
    logic        overflow;
  } result_t;

  typedef struct packed {
    logic signed [31:0] vehicle_x;
    logic signed [31:0] vehicle_y;
    logic signed [15:0] vehicle_heading;
    logic [30:0]        pos_threshold;
    logic [15:0]        angle_threshold;
    logic [31:0]        pos_weight;
    logic [31:0]        angle_weight;
  } cfg_t;

  // one classified candidate, as queued between front and back
  typedef struct packed {
    logic [31:0] ax;
    logic [31:0] ay;
    logic [15:0] adiff;
    logic [7:0]  index;
    logic        eval;
    logic        last;
    logic        ovf;
  } job_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_SQX,
    BK_SQY,
    BK_SUM,
    BK_ROOT,
    BK_GATE,
    BK_T1,
    BK_T2,
    BK_DONE
  } back_state_e;

endpackage

[sv/gnps_front.sv]
// gnps_front: accepts candidates, forms absolute differences and stream index.
// Depends on gnps_pkg.
`timescale 1ns / 1ps

module gnps_front #(
  parameter int unsigned MAX_CANDIDATES = 256
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  gnps_pkg::cfg_t cfg_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  gnps_pkg::cand_t in_data_i,
  input  logic           full_i,
  output logic           push_o,
  output gnps_pkg::job_t job_o
);
  import gnps_pkg::*;

  localparam int unsigned Cap  = (MAX_CANDIDATES < 256) ? MAX_CANDIDATES : 256;
  localparam int unsigned CntW = $clog2(Cap + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            ovf_q, ovf_d;
  logic            in_cap;
  logic [32:0]     dx, dy, ndx, ndy;
  logic [16:0]     dh, ndh;

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;
  assign in_cap     = cnt_q < CntW'(Cap);

  always_comb begin
    dx  = {cfg_i.vehicle_x[31], cfg_i.vehicle_x} - {in_data_i.cand_x[31], in_data_i.cand_x};
    dy  = {cfg_i.vehicle_y[31], cfg_i.vehicle_y} - {in_data_i.cand_y[31], in_data_i.cand_y};
    dh  = {cfg_i.vehicle_heading[15], cfg_i.vehicle_heading}
        - {in_data_i.cand_heading[15], in_data_i.cand_heading};
    ndx = ~dx + 33'd1;
    ndy = ~dy + 33'd1;
    ndh = ~dh + 17'd1;
    job_o.ax    = dx[32] ? ndx[31:0] : dx[31:0];
    job_o.ay    = dy[32] ? ndy[31:0] : dy[31:0];
    job_o.adiff = dh[16] ? ndh[15:0] : dh[15:0];
    job_o.index = 8'(cnt_q);
    job_o.eval  = in_cap;
    job_o.last  = in_data_i.last;
    job_o.ovf   = ovf_q || !in_cap;
  end

  always_comb begin
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    if (push_o) begin
      if (in_data_i.last) begin
        cnt_d = '0;
        ovf_d = 1'b0;
      end else if (in_cap) begin
        cnt_d = cnt_q + CntW'(1);
      end else begin
        ovf_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
    end
  end

endmodule

[sv/gnps_fifo.sv]
// gnps_fifo: short queue of classified candidates between front and back.
// Depends on gnps_pkg.
`timescale 1ns / 1ps

module gnps_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  gnps_pkg::job_t data_i,
  output logic           full_o,
  output logic           valid_o,
  input  logic           pop_i,
  output gnps_pkg::job_t data_o
);
  import gnps_pkg::*;

  localparam int unsigned PtrW = $clog2(QueueDepth);
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  job_t            slot_q [QueueDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign full_o  = cnt_q == CntW'(QueueDepth);
  assign valid_o = cnt_q != '0;
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;
  assign data_o  = slot_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PtrW'(QueueDepth - 1)) ? '0 : rd_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

[sv/gnps_back.sv]
// gnps_back: distance by bit-pair square root, gating, cost and running minimum.
// One shared 32x32 multiplier. Depends on gnps_pkg.
`timescale 1ns / 1ps

module gnps_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gnps_pkg::cfg_t    cfg_i,
  input  logic              job_valid_i,
  input  gnps_pkg::job_t    job_i,
  output logic              job_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output gnps_pkg::result_t out_data_o
);
  import gnps_pkg::*;

  back_state_e state_q, state_d;
  job_t        job_q;
  logic [63:0] prod_q, acc_q, v_q;
  logic [34:0] rem_q, rem_d;
  logic [31:0] root_q, root_d;
  logic [4:0]  step_q;
  logic [31:0] term_q, cost_q;
  logic        pass_q;
  logic [31:0] min_q;
  logic [7:0]  idx_q;
  logic        any_q;
  logic        out_valid_q;
  result_t     out_q;

  logic [31:0] mul_a, mul_b;
  logic        done_go, emit;
  logic        gate_pass;
  logic [64:0] sum;
  logic [34:0] rem_sh, trial;
  logic [31:0] t1, t2;
  logic [32:0] csum;
  logic        upd, nany;
  logic [31:0] nmin;
  logic [7:0]  nidx;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // square-root step: bring down two bits, try subtracting 4r+1
  always_comb begin
    rem_sh = {rem_q[32:0], v_q[63:62]};
    trial  = {1'b0, root_q, 2'b01};
    if (rem_sh >= trial) begin
      rem_d  = rem_sh - trial;
      root_d = {root_q[30:0], 1'b1};
    end else begin
      rem_d  = rem_sh;
      root_d = {root_q[30:0], 1'b0};
    end
  end

  always_comb begin
    sum       = {1'b0, acc_q} + {1'b0, prod_q};
    gate_pass = (root_q <= {1'b0, cfg_i.pos_threshold})
             && (job_q.adiff <= cfg_i.angle_threshold);
    t1        = (|prod_q[63:48]) ? '1 : prod_q[47:16];
    t2        = (|prod_q[63:45]) ? '1 : prod_q[44:13];
    csum      = {1'b0, term_q} + {1'b0, t2};
    upd       = pass_q && (!any_q || cost_q < min_q);
    nany      = any_q || upd;
    nmin      = upd ? cost_q : min_q;
    nidx      = upd ? job_q.index : idx_q;
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (job_valid_i) begin
          state_d = job_i.eval ? BK_SQX : BK_DONE;
        end
      end
      BK_SQX:  state_d = BK_SQY;
      BK_SQY:  state_d = BK_SUM;
      BK_SUM:  state_d = BK_ROOT;
      BK_ROOT: begin
        if (step_q == 5'(RootSteps - 1)) begin
          state_d = BK_GATE;
        end
      end
      BK_GATE: state_d = gate_pass ? BK_T1 : BK_DONE;
      BK_T1:   state_d = BK_T2;
      BK_T2:   state_d = BK_DONE;
      BK_DONE: begin
        if (done_go) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    job_pop_o = 1'b0;
    mul_a     = job_q.ax;
    mul_b     = job_q.ax;
    done_go   = 1'b0;
    emit      = 1'b0;
    case (state_q)
      BK_IDLE: job_pop_o = job_valid_i;
      BK_SQY: begin
        mul_a = job_q.ay;
        mul_b = job_q.ay;
      end
      BK_GATE: begin
        mul_a = root_q;
        mul_b = cfg_i.pos_weight;
      end
      BK_T1: begin
        mul_a = {16'd0, job_q.adiff};
        mul_b = cfg_i.angle_weight;
      end
      BK_DONE: begin
        done_go = !job_q.last || !out_valid_q || out_ready_i;
        emit    = done_go && job_q.last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
    case (state_q)
      BK_IDLE: begin
        job_q  <= job_i;
        pass_q <= 1'b0;
      end
      BK_SQY:  acc_q <= prod_q;
      BK_SUM: begin
        v_q    <= sum[64] ? '1 : sum[63:0];
        rem_q  <= '0;
        root_q <= '0;
        step_q <= '0;
      end
      BK_ROOT: begin
        v_q    <= {v_q[61:0], 2'b00};
        rem_q  <= rem_d;
        root_q <= root_d;
        step_q <= step_q + 5'd1;
      end
      BK_T1:   term_q <= t1;
      BK_T2: begin
        cost_q <= csum[32] ? '1 : csum[31:0];
        pass_q <= 1'b1;
      end
      default: ;
    endcase
    if (emit) begin
      out_q.found      <= nany;
      out_q.best_index <= nany ? nidx : '0;
      out_q.best_cost  <= nany ? nmin : '0;
      out_q.overflow   <= job_q.ovf;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      min_q       <= '1;
      idx_q       <= '0;
      any_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (done_go) begin
        if (job_q.last) begin
          min_q <= '1;
          idx_q <= '0;
          any_q <= 1'b0;
        end else begin
          min_q <= nmin;
          idx_q <= nidx;
          any_q <= nany;
        end
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

[sv/gated_nearest_pose_select.sv]
// Channel  | Handshake                  | Payload
// in       | in_valid_i / in_ready_o    | in_data_i  (gnps_pkg::cand_t)
// out      | out_valid_o / out_ready_i  | out_data_o (gnps_pkg::result_t)
// cfg      | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// An evaluated candidate occupies the back end through the 32-step square
// root and four passes through the shared multiplier; a candidate past
// capacity or failing the gate finishes sooner.
// The front takes a candidate whenever the two-entry queue has room.
// A result waits in the output register; only a last candidate stalls on it.
// Reset restores the register defaults and an empty search; no clearing pass.
//
// Top level: configuration registers and the front/queue/back chain.
// Depends on gnps_pkg, gnps_front, gnps_fifo, gnps_back.
`timescale 1ns / 1ps

module gated_nearest_pose_select #(
  parameter int unsigned MAX_CANDIDATES = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  gnps_pkg::cand_t   in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output gnps_pkg::result_t out_data_o,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [31:0]       cfg_data_i
);
  import gnps_pkg::*;

  cfg_t cfg_q;
  logic push, full, job_valid, job_pop;
  job_t job_in, job_out;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.vehicle_x       <= '0;
      cfg_q.vehicle_y       <= '0;
      cfg_q.vehicle_heading <= '0;
      cfg_q.pos_threshold   <= PosThresholdRst;
      cfg_q.angle_threshold <= AngThresholdRst;
      cfg_q.pos_weight      <= PosWeightRst;
      cfg_q.angle_weight    <= AngWeightRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegVehicleX:     cfg_q.vehicle_x       <= cfg_data_i;
        RegVehicleY:     cfg_q.vehicle_y       <= cfg_data_i;
        RegVehicleHead:  cfg_q.vehicle_heading <= cfg_data_i[15:0];
        RegPosThreshold: cfg_q.pos_threshold   <= cfg_data_i[30:0];
        RegAngThreshold: cfg_q.angle_threshold <= cfg_data_i[15:0];
        RegPosWeight:    cfg_q.pos_weight      <= cfg_data_i;
        RegAngWeight:    cfg_q.angle_weight    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  gnps_front #(
    .MAX_CANDIDATES(MAX_CANDIDATES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .full_i     (full),
    .push_o     (push),
    .job_o      (job_in)
  );

  gnps_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .full_o  (full),
    .valid_o (job_valid),
    .pop_i   (job_pop),
    .data_o  (job_out)
  );

  gnps_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .job_valid_i (job_valid),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

[sv/gnps_checker.sv]
// gnps_sva: port-level checks on the selector's result and register channels.
// Depends on gnps_pkg; bound to gated_nearest_pose_select below.
`timescale 1ns / 1ps

module gnps_sva (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input gnps_pkg::result_t out_data_o,
  input logic              cfg_valid_i,
  input logic              cfg_ready_o
);
  import gnps_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("result changed while stalled");

  a_empty_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.found |->
      out_data_o.best_index == 8'd0 && out_data_o.best_cost == 32'd0)
    else $error("empty search carries winner fields");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind gated_nearest_pose_select gnps_sva u_checker (.*);
